FILE: hw/rtl/qnf_pkg.sv
// ----------------------------------------------------------------------------
// qnf_pkg
// shared types and constants of the quadtree near/far classifier
// ----------------------------------------------------------------------------
`default_nettype none

package qnf_pkg;

	// depth fields (key depth, minimum depth) and the relation code
	localparam int DEPTH_W = 6;
	localparam int REL_W   = 3;

	typedef enum logic [REL_W-1:0] {
		REL_IDENTICAL = 3'd0,
		REL_NEAR      = 3'd1,
		REL_FAR       = 3'd2,
		REL_NONE      = 3'd3,
		REL_ORDER     = 3'd4
	} rel_t;

	// expansion control handed from the rescale stage to the diff stage
	typedef struct packed {
		logic               mode;
		logic               exp_a;
		logic               exp_b;
		logic [DEPTH_W-1:0] free_bits;
	} exp_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qnf_rescale.sv
// ----------------------------------------------------------------------------
// qnf_rescale
// clamps and masks both keys and brings them to the common depth
// ----------------------------------------------------------------------------
`default_nettype none

module qnf_rescale import qnf_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                 mode,
	input  wire logic [KEY_WIDTH-1:0] first_x,
	input  wire logic [KEY_WIDTH-1:0] first_y,
	input  wire logic [DEPTH_W-1:0]   first_depth,
	input  wire logic [KEY_WIDTH-1:0] second_x,
	input  wire logic [KEY_WIDTH-1:0] second_y,
	input  wire logic [DEPTH_W-1:0]   second_depth,
	input  wire logic [DEPTH_W-1:0]   min_depth,
	output logic      [KEY_WIDTH-1:0] sa_x,
	output logic      [KEY_WIDTH-1:0] sa_y,
	output logic      [KEY_WIDTH-1:0] sb_x,
	output logic      [KEY_WIDTH-1:0] sb_y,
	output exp_ctl_t                  ctl
);

	localparam logic [DEPTH_W:0]   KW_D   = (DEPTH_W+1)'(KEY_WIDTH);
	localparam logic [DEPTH_W-1:0] KW_SAT = DEPTH_W'(KEY_WIDTH);

	logic [DEPTH_W-1:0]   da, db, dmd, deeper, shallower, tgt;
	logic [KEY_WIDTH-1:0] ma, mb, ax, ay, bx, by;

	// depths saturate at the key width
	assign da  = ({1'b0, first_depth}  > KW_D) ? KW_SAT : first_depth;
	assign db  = ({1'b0, second_depth} > KW_D) ? KW_SAT : second_depth;
	assign dmd = ({1'b0, min_depth}    > KW_D) ? KW_SAT : min_depth;

	always_comb begin
		for (int i = 0; i < KEY_WIDTH; i++) begin
			ma[i] = (DEPTH_W+1)'(i) < {1'b0, da};
			mb[i] = (DEPTH_W+1)'(i) < {1'b0, db};
		end
	end

	// bits at or above a key's depth are dropped
	assign ax = first_x  & ma;
	assign ay = first_y  & ma;
	assign bx = second_x & mb;
	assign by = second_y & mb;

	assign deeper    = (da > db) ? da : db;
	assign shallower = (da < db) ? da : db;
	assign tgt       = mode ? ((dmd > deeper) ? deeper : dmd) : shallower;

	always_comb begin
		if (da > tgt) begin
			sa_x = ax >> (da - tgt);
			sa_y = ay >> (da - tgt);
		end else begin
			sa_x = ax << (tgt - da);
			sa_y = ay << (tgt - da);
		end
		if (db > tgt) begin
			sb_x = bx >> (db - tgt);
			sb_y = by >> (db - tgt);
		end else begin
			sb_x = bx << (tgt - db);
			sb_y = by << (tgt - db);
		end
	end

	// the first key takes precedence when both gained depth
	always_comb begin
		ctl.mode      = mode;
		ctl.exp_a     = mode && (da < tgt);
		ctl.exp_b     = mode && !(da < tgt) && (db < tgt);
		ctl.free_bits = (da < tgt) ? (tgt - da) : (tgt - db);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/qnf_diff_expand.sv
// ----------------------------------------------------------------------------
// qnf_diff_expand
// finds the highest differing level, the order check and the mode 1 expansion
// ----------------------------------------------------------------------------
`default_nettype none

module qnf_diff_expand import qnf_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic [KEY_WIDTH-1:0] sa_x,
	input  wire logic [KEY_WIDTH-1:0] sa_y,
	input  wire logic [KEY_WIDTH-1:0] sb_x,
	input  wire logic [KEY_WIDTH-1:0] sb_y,
	input  exp_ctl_t                  ctl,
	output logic      [KEY_WIDTH-1:0] ea_x,
	output logic      [KEY_WIDTH-1:0] ea_y,
	output logic      [KEY_WIDTH-1:0] eb_x,
	output logic      [KEY_WIDTH-1:0] eb_y,
	output logic                      ooo
);

	localparam int IW = $clog2(KEY_WIDTH + 1);
	localparam int SW = $clog2(KEY_WIDTH);

	logic [KEY_WIDTH-1:0] xr, yr, dif, fill, kx, ky, rx, ry, nx, ny;
	logic [IW-1:0]        idx;
	logic [SW-1:0]        pos;
	logic [1:0]           qa, qb;
	logic                 do_exp;

	assign xr  = sa_x ^ sb_x;
	assign yr  = sa_y ^ sb_y;
	assign dif = xr | yr;

	// level of the highest set bit, 0 when the keys match
	always_comb begin
		idx = '0;
		for (int i = 0; i < KEY_WIDTH; i++) begin
			if (dif[i]) idx = IW'(i + 1);
		end
	end

	assign pos = SW'(idx - IW'(1));
	assign qa  = {sa_y[pos], sa_x[pos]};
	assign qb  = {sb_y[pos], sb_x[pos]};
	assign ooo = (idx != '0) && (qa > qb);

	always_comb begin
		for (int i = 0; i < KEY_WIDTH; i++) begin
			fill[i] = (DEPTH_W+1)'(i) < {1'b0, ctl.free_bits};
		end
	end

	// expanded key and its partner
	assign kx = ctl.exp_a ? sa_x : sb_x;
	assign ky = ctl.exp_a ? sa_y : sb_y;
	assign rx = ctl.exp_a ? sb_x : sa_x;
	assign ry = ctl.exp_a ? sb_y : sa_y;

	assign nx = xr[pos] ? ((kx & ~fill) | (rx[pos] ? fill : '0)) : rx;
	assign ny = yr[pos] ? ((ky & ~fill) | (ry[pos] ? fill : '0)) : ry;

	assign do_exp = ctl.mode && (ctl.exp_a || ctl.exp_b) && (idx > IW'(1)) && !ooo;

	assign ea_x = (do_exp && ctl.exp_a) ? nx : sa_x;
	assign ea_y = (do_exp && ctl.exp_a) ? ny : sa_y;
	assign eb_x = (do_exp && ctl.exp_b) ? nx : sb_x;
	assign eb_y = (do_exp && ctl.exp_b) ? ny : sb_y;

endmodule

`default_nettype wire

FILE: hw/rtl/qnf_classify.sv
// ----------------------------------------------------------------------------
// qnf_classify
// chebyshev distance and parent check, giving the relation code
// ----------------------------------------------------------------------------
`default_nettype none

module qnf_classify import qnf_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic [KEY_WIDTH-1:0] a_x,
	input  wire logic [KEY_WIDTH-1:0] a_y,
	input  wire logic [KEY_WIDTH-1:0] b_x,
	input  wire logic [KEY_WIDTH-1:0] b_y,
	input  wire logic                 ooo,
	output rel_t                      rel
);

	logic [KEY_WIDTH-1:0] dx, dy, d, pax, pay, pbx, pby, pdx, pdy, pd;

	assign dx = (a_x < b_x) ? (b_x - a_x) : (a_x - b_x);
	assign dy = (a_y < b_y) ? (b_y - a_y) : (a_y - b_y);
	assign d  = (dx > dy) ? dx : dy;

	// parents, one level up
	assign pax = a_x >> 1;
	assign pay = a_y >> 1;
	assign pbx = b_x >> 1;
	assign pby = b_y >> 1;
	assign pdx = (pax < pbx) ? (pbx - pax) : (pax - pbx);
	assign pdy = (pay < pby) ? (pby - pay) : (pay - pby);
	assign pd  = (pdx > pdy) ? pdx : pdy;

	always_comb begin
		if (ooo)                             rel = REL_ORDER;
		else if (d == KEY_WIDTH'(0))         rel = REL_IDENTICAL;
		else if (d == KEY_WIDTH'(1))         rel = REL_NEAR;
		else if (d == KEY_WIDTH'(2))         rel = REL_FAR;
		else if (d == KEY_WIDTH'(3) && pd < KEY_WIDTH'(2)) rel = REL_FAR;
		else                                 rel = REL_NONE;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/quadtree_near_far_classifier_unit.sv
// ----------------------------------------------------------------------------
// quadtree_near_far_classifier_unit
// classifies a pair of quadtree node keys for a multipole traversal
// ----------------------------------------------------------------------------
// input channel (in_valid / in_ready) carries one key pair per transaction:
//   mode, both keys (x, y, depth) and min_depth for mode 1
// output channel (out_valid / out_ready) returns one relation per pair:
//   identical, near, far, no interaction or out of order
// pipeline: input register, rescale stage, diff/expand stage, classify into
//   the output register; an accepted transaction passes the rescale and
//   diff/expand registers in order before its result reaches the output
// throughput: 1 transaction per cycle while out_ready stays high; every stage
//   holds one pair and moves on whenever the stage after it is empty or moving
// stall: with out_ready low the output register holds its result, the
//   stages behind it fill up, and in_ready falls once all four are full
// reset: arst_n clears all stage valid bits, nothing else needs clearing
// ----------------------------------------------------------------------------
`default_nettype none

module quadtree_near_far_classifier_unit import qnf_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 mode,
	input  wire logic [KEY_WIDTH-1:0] first_x,
	input  wire logic [KEY_WIDTH-1:0] first_y,
	input  wire logic [DEPTH_W-1:0]   first_depth,
	input  wire logic [KEY_WIDTH-1:0] second_x,
	input  wire logic [KEY_WIDTH-1:0] second_y,
	input  wire logic [DEPTH_W-1:0]   second_depth,
	input  wire logic [DEPTH_W-1:0]   min_depth,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [REL_W-1:0]     relation
);

	// stage valids and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1: raw input transaction
	logic                 mode_s1;
	logic [KEY_WIDTH-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic [DEPTH_W-1:0]   ad_s1, bd_s1, md_s1;

	// stage 2: keys at common depth plus expansion control
	logic [KEY_WIDTH-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	exp_ctl_t             ctl_s2;

	// stage 3: expanded keys and order flag
	logic [KEY_WIDTH-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic                 ooo_s3;

	// stage 4: result register
	rel_t                 rel_s4;

	// combinational stage outputs
	logic [KEY_WIDTH-1:0] sa_x, sa_y, sb_x, sb_y;
	exp_ctl_t             ctl_c;
	logic [KEY_WIDTH-1:0] ea_x, ea_y, eb_x, eb_y;
	logic                 ooo_c;
	rel_t                 rel_c;

	// a stage takes new data when it is empty or its contents move on
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1 <= mode;
			ax_s1   <= first_x;
			ay_s1   <= first_y;
			ad_s1   <= first_depth;
			bx_s1   <= second_x;
			by_s1   <= second_y;
			bd_s1   <= second_depth;
			md_s1   <= min_depth;
		end
		if (rdy2 && v_s1) begin
			ax_s2  <= sa_x;
			ay_s2  <= sa_y;
			bx_s2  <= sb_x;
			by_s2  <= sb_y;
			ctl_s2 <= ctl_c;
		end
		if (rdy3 && v_s2) begin
			ax_s3  <= ea_x;
			ay_s3  <= ea_y;
			bx_s3  <= eb_x;
			by_s3  <= eb_y;
			ooo_s3 <= ooo_c;
		end
		if (rdy4 && v_s3) begin
			rel_s4 <= rel_c;
		end
	end

	// clamp, mask and bring both keys to the target depth
	qnf_rescale #(.KEY_WIDTH(KEY_WIDTH)) u_rescale (
		.mode         (mode_s1),
		.first_x      (ax_s1),
		.first_y      (ay_s1),
		.first_depth  (ad_s1),
		.second_x     (bx_s1),
		.second_y     (by_s1),
		.second_depth (bd_s1),
		.min_depth    (md_s1),
		.sa_x         (sa_x),
		.sa_y         (sa_y),
		.sb_x         (sb_x),
		.sb_y         (sb_y),
		.ctl          (ctl_c)
	);

	// highest differing level, order check, mode 1 expansion
	qnf_diff_expand #(.KEY_WIDTH(KEY_WIDTH)) u_diff (
		.sa_x (ax_s2),
		.sa_y (ay_s2),
		.sb_x (bx_s2),
		.sb_y (by_s2),
		.ctl  (ctl_s2),
		.ea_x (ea_x),
		.ea_y (ea_y),
		.eb_x (eb_x),
		.eb_y (eb_y),
		.ooo  (ooo_c)
	);

	// distance classification
	qnf_classify #(.KEY_WIDTH(KEY_WIDTH)) u_classify (
		.a_x (ax_s3),
		.a_y (ay_s3),
		.b_x (bx_s3),
		.b_y (by_s3),
		.ooo (ooo_s3),
		.rel (rel_c)
	);

	assign out_valid = v_s4;
	assign relation  = rel_s4;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// backpressure only ever starts at a stalled output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a stalled result");

	// at most one key is picked for expansion
	a_one_expand: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(ctl_s2.exp_a && ctl_s2.exp_b))
		else $error("both keys marked for expansion");

	// an out-of-order pair lands in the output register as out of order
	a_order_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4 && ooo_s3) |=> (out_valid && relation == REL_ORDER))
		else $error("out-of-order pair lost its relation code");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the quadtree near/far classifier
// ----------------------------------------------------------------------------
// key pairs are queued up front: a short directed list of corner cases, then
// random pairs, mostly keys placed a few cells apart so that every relation
// shows up, the rest pure noise. a driver feeds them over the input channel,
// and a predictor works out the relation of each accepted pair. a monitor
// checks every returned relation in order. both sides idle at random, and
// the receiver now and then holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------

module testbench;
	import qnf_pkg::*;

	localparam int KW           = 32;
	localparam int LATENCY      = 3;
	localparam int DRAIN_CYCLES = 4 * LATENCY + 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_PAIRS = 2000;
	localparam int HOLD_CYCLES  = 60;
	localparam int HOLD_STEP    = 700;
	localparam int CALM_FROM    = 600;
	localparam int CALM_TO      = 1000;

	localparam logic MODE_SHALLOW   = 1'b0;
	localparam logic MODE_MIN_DEPTH = 1'b1;

	typedef logic [KW-1:0]      coord_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	// one quadtree node at a given level
	typedef struct {
		coord_t      x;
		coord_t      y;
		int unsigned lvl;
	} node_t;

	// one input transaction as driven on the ports
	typedef struct {
		logic   mode;
		coord_t ax;
		coord_t ay;
		depth_t ad;
		coord_t bx;
		coord_t by;
		depth_t bd;
		depth_t md;
	} pair_t;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   in_valid     = 1'b0;
	logic   out_ready    = 1'b0;
	logic   mode         = 1'b0;
	coord_t first_x      = '0;
	coord_t first_y      = '0;
	depth_t first_depth  = '0;
	coord_t second_x     = '0;
	coord_t second_y     = '0;
	depth_t second_depth = '0;
	depth_t min_depth    = '0;
	logic   in_ready;
	logic   out_valid;
	logic   [REL_W-1:0] relation;

	pair_t pair_backlog[$];    // pairs not yet offered
	rel_t  relation_due[$];    // relations predicted, not yet returned
	pair_t on_wire;            // pair currently held on the input ports
	bit    pair_taken   = 1'b0;
	int    total_pairs  = -1;
	int    pairs_sent   = 0;
	int    results_seen = 0;
	int    mismatches   = 0;
	int    idle_cycles  = 0;
	int    hold_left    = 0;
	int    holds_done   = 0;
	int    next_hold_at = 300;
	int    rel_seen[5]  = '{default: 0};

	quadtree_near_far_classifier_unit #(
		.KEY_WIDTH(KW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.first_x     (first_x),
		.first_y     (first_y),
		.first_depth (first_depth),
		.second_x    (second_x),
		.second_y    (second_y),
		.second_depth(second_depth),
		.min_depth   (min_depth),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.relation    (relation)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// relation predictor
	// ------------------------------------------------------------------------

	// depth fields above the key width saturate
	function automatic int unsigned clamp_level(depth_t d);
		return (d > KW) ? KW : d;
	endfunction

	// ones in the n low bits
	function automatic coord_t level_mask(int unsigned n);
		coord_t ones;
		ones = '1;
		return (n >= KW) ? ones : ~(ones << n);
	endfunction

	// move a node to another level, dropping or appending low bits
	function automatic node_t rescale_node(node_t k, int unsigned target);
		node_t r;
		if (k.lvl > target) begin
			r.x = k.x >> (k.lvl - target);
			r.y = k.y >> (k.lvl - target);
		end else begin
			r.x = k.x << (target - k.lvl);
			r.y = k.y << (target - k.lvl);
		end
		r.lvl = target;
		return r;
	endfunction

	// position of the highest set bit, counted from 1, 0 for no bit set
	function automatic int unsigned top_level(coord_t v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < KW; i++)
			if (v[i])
				n = i + 1;
		return n;
	endfunction

	// highest level where two nodes differ, and the axes that differ there
	function automatic int unsigned diff_level(node_t a, node_t b, output logic [1:0] axes);
		coord_t      xr, yr;
		int unsigned ix, iy, lv;
		xr   = a.x ^ b.x;
		yr   = a.y ^ b.y;
		ix   = top_level(xr);
		iy   = top_level(yr);
		lv   = (ix > iy) ? ix : iy;
		axes = 2'b00;
		if (lv != 0)
			axes = {yr[lv-1], xr[lv-1]};
		return lv;
	endfunction

	// first key sits in a later child quadrant at the split level
	function automatic bit out_of_order(node_t a, node_t b);
		logic [1:0]  axes;
		int unsigned lv;
		lv = diff_level(a, b, axes);
		if (lv == 0)
			return 1'b0;
		return {a.y[lv-1], a.x[lv-1]} > {b.y[lv-1], b.x[lv-1]};
	endfunction

	// chebyshev distance
	function automatic coord_t node_distance(node_t a, node_t b);
		coord_t dx, dy;
		dx = (a.x < b.x) ? b.x - a.x : a.x - b.x;
		dy = (a.y < b.y) ? b.y - a.y : a.y - b.y;
		return (dx > dy) ? dx : dy;
	endfunction

	function automatic rel_t distance_relation(node_t a, node_t b);
		coord_t d;
		d = node_distance(a, b);
		if (d == 0)
			return REL_IDENTICAL;
		if (d == 1)
			return REL_NEAR;
		if (d == 2)
			return REL_FAR;
		if (d == 3) begin
			// three cells apart: far only when the parents still touch
			a.x = a.x >> 1;
			a.y = a.y >> 1;
			b.x = b.x >> 1;
			b.y = b.y >> 1;
			if (node_distance(a, b) < 2)
				return REL_FAR;
		end
		return REL_NONE;
	endfunction

	// pull a scaled-up node toward its partner through its free low bits
	function automatic node_t expand_node(node_t k, node_t partner, int unsigned lv,
			logic [1:0] axes, int unsigned free_bits);
		coord_t fill;
		fill = level_mask(free_bits);
		if (lv <= 1 || free_bits == 0)
			return k;
		if (axes[0])
			k.x = (k.x & ~fill) | (partner.x[lv-1] ? fill : '0);
		else
			k.x = partner.x;
		if (axes[1])
			k.y = (k.y & ~fill) | (partner.y[lv-1] ? fill : '0);
		else
			k.y = partner.y;
		return k;
	endfunction

	function automatic rel_t predict_relation(pair_t p);
		node_t       a, b, sa, sb;
		int unsigned target, deeper, lv;
		logic [1:0]  axes;
		a.lvl = clamp_level(p.ad);
		a.x   = p.ax & level_mask(a.lvl);
		a.y   = p.ay & level_mask(a.lvl);
		b.lvl = clamp_level(p.bd);
		b.x   = p.bx & level_mask(b.lvl);
		b.y   = p.by & level_mask(b.lvl);
		if (p.mode == MODE_SHALLOW) begin
			target = (a.lvl < b.lvl) ? a.lvl : b.lvl;
			sa = rescale_node(a, target);
			sb = rescale_node(b, target);
			if (out_of_order(sa, sb))
				return REL_ORDER;
			return distance_relation(sa, sb);
		end
		deeper = (a.lvl > b.lvl) ? a.lvl : b.lvl;
		target = clamp_level(p.md);
		if (target > deeper)
			target = deeper;
		sa = rescale_node(a, target);
		sb = rescale_node(b, target);
		if (out_of_order(sa, sb))
			return REL_ORDER;
		lv = diff_level(sa, sb, axes);
		if (lv == 0)
			return REL_IDENTICAL;
		if (a.lvl < target)
			sa = expand_node(sa, sb, lv, axes, target - a.lvl);
		else if (b.lvl < target)
			sb = expand_node(sb, sa, lv, axes, target - b.lvl);
		return distance_relation(sa, sb);
	endfunction

	function automatic pair_t key_pair(logic m, coord_t ax, coord_t ay, int unsigned ad,
			coord_t bx, coord_t by, int unsigned bd, int unsigned md);
		pair_t p;
		p.mode = m;
		p.ax   = ax;
		p.ay   = ay;
		p.ad   = depth_t'(ad);
		p.bx   = bx;
		p.by   = by;
		p.bd   = depth_t'(bd);
		p.md   = depth_t'(md);
		return p;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	// ------------------------------------------------------------------------
	// driver: a new pair goes out once the previous one was taken, or after
	// an idle cycle; the pair stays on the ports until the block accepts it
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pair_taken)) begin
			if (pair_backlog.size() != 0 &&
					((pairs_sent >= CALM_FROM && pairs_sent < CALM_TO) ||
					$urandom_range(0, 99) >= 15)) begin
				on_wire = pair_backlog.pop_front();
				in_valid     <= 1'b1;
				mode         <= on_wire.mode;
				first_x      <= on_wire.ax;
				first_y      <= on_wire.ay;
				first_depth  <= on_wire.ad;
				second_x     <= on_wire.bx;
				second_y     <= on_wire.by;
				second_depth <= on_wire.bd;
				min_depth    <= on_wire.md;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, an idle-free stretch, and every so often a
	// long hold-off while the driver keeps offering pairs
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			next_hold_at <= next_hold_at + HOLD_STEP;
			hold_left    <= HOLD_CYCLES - 1;
			holds_done   <= holds_done + 1;
			out_ready    <= 1'b0;
		end else begin
			out_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
				$urandom_range(0, 99) >= 15;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predict on each accepted pair, check each returned relation
	// against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rel_t want;
		pair_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			relation_due.push_back(predict_relation(on_wire));
			pairs_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (relation_due.size() == 0) begin
				report_mismatch($sformatf("relation %0d with no pair outstanding", relation));
			end else begin
				want = relation_due.pop_front();
				rel_seen[want]++;
				if (relation !== want)
					report_mismatch($sformatf("relation %0d, expected %0d (%s)",
						relation, want, want.name()));
			end
			results_seen++;
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		pair_t       p;
		int unsigned da, db, lo, hi, sh;
		int          ox, oy;
		int          directed_pairs;

		// identical keys at full depth and at the root
		pair_backlog.push_back(key_pair(MODE_SHALLOW, '1, '1, 32, '1, '1, 32, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 0, 0, 0, 0, 0, 0, 0));
		// neighbor, two apart, three apart with touching and distant parents, far apart
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 5, 5, 4, 6, 5, 4, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 5, 5, 4, 7, 4, 4, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 4, 5, 4, 7, 5, 4, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 5, 5, 4, 8, 5, 4, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 0, 0, 8, 200, 0, 8, 0));
		// first key in the later quadrant
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 1, 0, 1, 0, 0, 1, 0));
		// depth fields beyond the key width saturate
		pair_backlog.push_back(key_pair(MODE_SHALLOW, '1, '1, 63, '1, '1, 40, 0));
		// junk above the depth is ignored
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 32'hFFFF_FF05, 32'hABCD_0005, 4,
			6, 5, 4, 0));
		// unequal depths, deeper key falls onto the shallow one; opposite corners
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 3, 1, 2, 13, 5, 4, 0));
		pair_backlog.push_back(key_pair(MODE_SHALLOW, 0, 0, 32, '1, '1, 32, 0));
		// min depth of zero, and min depth beyond both keys
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, '1, 0, 32, 0, '1, 32, 0));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 1, 1, 2, 6, 5, 4, 63));
		// expansion on both axes, on one axis, and on the second key
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 0, 0, 1, 8, 8, 4, 4));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 0, 1, 1, 8, 9, 4, 4));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 0, 0, 4, 1, 1, 1, 4));
		// split at the lowest level: no expansion
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 2, 0, 3, 5, 0, 4, 4));
		// equal depths, nothing gained
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 9, 20, 5, 11, 22, 5, 3));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 3, 3, 2, 0, 0, 2, 2));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 5, 5, 4, 8, 5, 4, 4));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, '1, '1, 32, 32'hFFFF_FFFE, '1, 32, 40));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, 32'hFFFF_FFFE, '1, 32, '1, '1, 32, 40));
		pair_backlog.push_back(key_pair(MODE_MIN_DEPTH, '1, '1, 63, '1, '1, 63, 63));
		directed_pairs = pair_backlog.size();

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				// noise over every field
				pair_backlog.push_back(key_pair(1'($urandom_range(0, 1)), $urandom, $urandom,
					$urandom_range(0, 63), $urandom, $urandom, $urandom_range(0, 63),
					$urandom_range(0, 63)));
			end else begin
				// second key placed a few cells from the first at some level
				da = $urandom_range(0, KW);
				db = ($urandom_range(0, 3) == 0) ? da : $urandom_range(0, KW);
				lo = (da < db) ? da : db;
				hi = (da > db) ? da : db;
				p = key_pair(1'($urandom_range(0, 1)), $urandom & level_mask(da),
					$urandom & level_mask(da), da, 0, 0, db, 0);
				if (db >= da) begin
					p.bx = (p.ax << (db - da)) | ($urandom & level_mask(db - da));
					p.by = (p.ay << (db - da)) | ($urandom & level_mask(db - da));
				end else begin
					p.bx = p.ax >> (da - db);
					p.by = p.ay >> (da - db);
				end
				ox   = $urandom_range(0, 6) - 3;
				oy   = $urandom_range(0, 6) - 3;
				sh   = $urandom_range(0, db - lo);
				p.bx = (p.bx + (coord_t'(ox) << sh)) & level_mask(db);
				p.by = (p.by + (coord_t'(oy) << sh)) & level_mask(db);
				p.md = ($urandom_range(0, 3) == 0) ? depth_t'($urandom_range(0, 63)) :
					depth_t'($urandom_range(lo, hi));
				if ($urandom_range(0, 4) == 0) begin
					p.ax = p.ax | ($urandom & ~level_mask(da));
					p.by = p.by | ($urandom & ~level_mask(db));
				end
				if (da == KW && $urandom_range(0, 3) == 0)
					p.ad = depth_t'($urandom_range(KW + 1, 63));
				if (db == KW && $urandom_range(0, 3) == 0)
					p.bd = depth_t'($urandom_range(KW + 1, 63));
				if ($urandom_range(0, 1) == 1)
					p = key_pair(p.mode, p.bx, p.by, p.bd, p.ax, p.ay, p.ad, p.md);
				pair_backlog.push_back(p);
			end
		end
		total_pairs = pair_backlog.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all pairs in, all relations back, then a DRAIN_CYCLES wait for stragglers
		while (pairs_sent != total_pairs || relation_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d key pairs (%0d directed), %0d receiver hold-offs of %0d cycles",
			total_pairs, directed_pairs, holds_done, HOLD_CYCLES);
		$display("relations: identical %0d, near %0d, far %0d, none %0d, out of order %0d",
			rel_seen[REL_IDENTICAL], rel_seen[REL_NEAR], rel_seen[REL_FAR],
			rel_seen[REL_NONE], rel_seen[REL_ORDER]);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/qnf_pkg.sv
hw/rtl/qnf_rescale.sv
hw/rtl/qnf_diff_expand.sv
hw/rtl/qnf_classify.sv
hw/rtl/quadtree_near_far_classifier_unit.sv
tb/testbench.sv
